### rtl/core/fss_pkg.sv
// shared types, constants and helper functions for the fuzzy subsequence scorer
`default_nettype none
package fss_pkg;

  localparam int PAT_DEPTH  = 64;
  localparam int PAT_AW     = $clog2(PAT_DEPTH);
  localparam int LEN_W      = $clog2(PAT_DEPTH + 1);
  localparam int TPOS_W     = 16;
  localparam int ACC_W      = 20;
  localparam int BONUS_W    = 13;
  localparam int SCORE_W    = 32;

  localparam logic [TPOS_W-1:0] TEXT_LIMIT = 16'd65535;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;
  localparam logic [1:0] OP_EMPTY  = 2'd3;

  localparam logic [SCORE_W-1:0] SCORE_EXACT  = 32'd10000;
  localparam logic [SCORE_W-1:0] SCORE_PREFIX = 32'd5000;
  localparam logic [SCORE_W-1:0] SCORE_EMPTY  = 32'd1;

  localparam logic [BONUS_W-1:0] PTS_MATCH = 13'd100;
  localparam logic [BONUS_W-1:0] PTS_RUN   = 13'd50;
  localparam logic [BONUS_W-1:0] PTS_START = 13'd200;
  localparam logic [BONUS_W-1:0] PTS_SEP   = 13'd150;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               matched;
  } result_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == 8'h2f) || (c == 8'h5f) || (c == 8'h2d) || (c == 8'h2e);
  endfunction

endpackage
`default_nettype wire

### rtl/core/fss_ram.sv
// generic ram: one write port, two registered read ports
`default_nettype none
module fss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

### rtl/core/fss_out_queue.sv
// two-entry result queue between the scoring logic and the output channel
`default_nettype none
module fss_out_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire fss_pkg::result_t push_data,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output fss_pkg::result_t      out_data
);

  fss_pkg::result_t ent [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = ent[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### rtl/core/fuzzy_subsequence_scorer_core.sv
// fuzzy subsequence scorer: top level with scan state, pattern ram and result queue
//
// input channel s_*: s_tuser carries the command (clear pattern, append pattern
// byte, text byte, empty candidate), s_tdata the byte, s_tlast ends a candidate.
// output channel m_*: one item per candidate, m_tdata the signed score and
// m_tuser the matched flag.
// the pattern sits in a 64-entry ram with two registered read ports; the ram
// addresses follow the next text position and next pattern index, so the
// bytes needed by an item are already read when it arrives.
// throughput: one item per cycle while s_tready is high, text and pattern alike.
// a result is queued as its last byte is accepted, shown on m_* after older ones.
// reset clears the pattern length and the scan state; ram contents are not
// cleared, there is no clearing pass and the block is ready right after reset.
// a stalled receiver fills a two-entry result queue; s_tready drops only
// while both entries hold results.
`default_nettype none
module fuzzy_subsequence_scorer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic [1:0]  s_tuser,   // [1:0] op
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] score
  output logic             m_tuser    // [0] matched
);

  localparam int AW  = fss_pkg::PAT_AW;
  localparam int LW  = fss_pkg::LEN_W;
  localparam int TW  = fss_pkg::TPOS_W;
  localparam int CW  = fss_pkg::ACC_W;
  localparam int BW  = fss_pkg::BONUS_W;

  // scan state
  logic [LW-1:0]        len, len_next;
  logic [TW-1:0]        tpos, tpos_next;
  logic [LW-1:0]        pidx, pidx_next;
  logic [LW-1:0]        run, run_next;
  logic                 started, started_next;
  logic                 prefix, prefix_next;
  logic [7:0]           prev, prev_next;
  logic signed [CW-1:0] acc, acc_next;

  logic                 accept;
  logic                 full;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [7:0]           ram_rd_t, ram_rd_p;
  logic [7:0]           rd_t, rd_p;
  logic                 fwd_t, fwd_p;
  logic [7:0]           fwd_data;

  // text byte update
  logic [7:0]           fc;
  logic                 take;
  logic                 tcmp;
  logic                 pact;
  logic                 hit;
  logic [LW-1:0]        run_inc;
  logic [BW-1:0]        bonus;
  logic [TW-1:0]        u_tpos;
  logic [LW-1:0]        u_pidx, u_run;
  logic                 u_started, u_prefix;
  logic signed [CW-1:0] u_acc;

  // finish
  logic                 push;
  logic [TW-1:0]        f_tlen;
  logic [LW-1:0]        f_pidx;
  logic                 f_prefix;
  logic signed [CW-1:0] f_acc;
  logic signed [CW:0]   f_diff;
  fss_pkg::result_t     res;
  fss_pkg::result_t     q_data;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  assign we    = accept && (s_tuser == fss_pkg::OP_APPEND) &&
                 (len < LW'(fss_pkg::PAT_DEPTH));
  assign waddr = len[AW-1:0];

  fss_ram #(
    .WIDTH (8),
    .DEPTH (fss_pkg::PAT_DEPTH)
  ) u_pat_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (s_tdata),
    .raddr_a (tpos_next[AW-1:0]),
    .rdata_a (ram_rd_t),
    .raddr_b (pidx_next[AW-1:0]),
    .rdata_b (ram_rd_p)
  );

  // write-through for a read of the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_t <= 1'b0;
      fwd_p <= 1'b0;
    end else begin
      fwd_t <= we && (waddr == tpos_next[AW-1:0]);
      fwd_p <= we && (waddr == pidx_next[AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_data <= s_tdata;
    end
  end

  assign rd_t = fwd_t ? fwd_data : ram_rd_t;
  assign rd_p = fwd_p ? fwd_data : ram_rd_p;

  // one text byte against the running scan state
  always_comb begin
    fc        = fss_pkg::fold(s_tdata);
    take      = (s_tuser == fss_pkg::OP_TEXT) && (tpos < fss_pkg::TEXT_LIMIT);
    tcmp      = tpos < TW'(len);
    pact      = take && (pidx < len);
    hit       = fss_pkg::fold(rd_p) == fc;
    run_inc   = run + LW'(1);
    bonus     = fss_pkg::PTS_MATCH;
    if (run_inc >= LW'(2)) begin
      bonus = bonus + BW'(run_inc) * fss_pkg::PTS_RUN;
    end
    if (tpos == '0) begin
      bonus = bonus + fss_pkg::PTS_START;
    end else if (fss_pkg::is_sep(prev)) begin
      bonus = bonus + fss_pkg::PTS_SEP;
    end

    u_tpos    = take ? tpos + TW'(1) : tpos;
    u_prefix  = prefix && !(take && tcmp && (fc != fss_pkg::fold(rd_t)));
    u_pidx    = pidx;
    u_run     = run;
    u_started = started;
    u_acc     = acc;
    if (pact) begin
      if (!hit) begin
        u_run = '0;
        if (started) begin
          u_acc = acc - CW'(1);
        end
      end else begin
        u_started = 1'b1;
        u_run     = run_inc;
        u_acc     = acc + $signed(CW'(bonus));
        u_pidx    = pidx + LW'(1);
      end
    end
  end

  // result for a text byte flagged last, or for an empty candidate
  always_comb begin
    push = accept && ((s_tuser == fss_pkg::OP_EMPTY) ||
                      ((s_tuser == fss_pkg::OP_TEXT) && s_tlast));
    if (s_tuser == fss_pkg::OP_TEXT) begin
      f_tlen   = u_tpos;
      f_pidx   = u_pidx;
      f_prefix = u_prefix;
      f_acc    = u_acc;
    end else begin
      f_tlen   = '0;
      f_pidx   = '0;
      f_prefix = 1'b1;
      f_acc    = '0;
    end
    f_diff = {f_acc[CW-1], f_acc} - $signed({1'b0, CW'(f_tlen)});

    res.score   = '0;
    res.matched = 1'b0;
    if (len == '0) begin
      res.score   = fss_pkg::SCORE_EMPTY;
      res.matched = 1'b1;
    end else if (TW'(len) > f_tlen) begin
      res.matched = 1'b0;
    end else if (f_prefix) begin
      res.score   = (f_tlen == TW'(len)) ? fss_pkg::SCORE_EXACT : fss_pkg::SCORE_PREFIX;
      res.matched = 1'b1;
    end else if (f_pidx >= len) begin
      // the score range stays far inside 32 bits, so no clamp is reached
      res.score   = fss_pkg::SCORE_W'(f_diff);
      res.matched = 1'b1;
    end
  end

  // next scan state
  always_comb begin
    len_next     = len;
    tpos_next    = tpos;
    pidx_next    = pidx;
    run_next     = run;
    started_next = started;
    prefix_next  = prefix;
    prev_next    = prev;
    acc_next     = acc;
    if (accept) begin
      // every command restarts the scan except a text byte that is not last
      tpos_next    = '0;
      pidx_next    = '0;
      run_next     = '0;
      started_next = 1'b0;
      prefix_next  = 1'b1;
      prev_next    = '0;
      acc_next     = '0;
      unique case (s_tuser)
        fss_pkg::OP_CLEAR: begin
          len_next = '0;
        end
        fss_pkg::OP_APPEND: begin
          if (we) begin
            len_next = len + LW'(1);
          end
        end
        fss_pkg::OP_TEXT: begin
          if (!s_tlast) begin
            tpos_next    = u_tpos;
            pidx_next    = u_pidx;
            run_next     = u_run;
            started_next = u_started;
            prefix_next  = u_prefix;
            prev_next    = take ? s_tdata : prev;
            acc_next     = u_acc;
          end
        end
        fss_pkg::OP_EMPTY: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      tpos    <= '0;
      pidx    <= '0;
      run     <= '0;
      started <= 1'b0;
      prefix  <= 1'b1;
      prev    <= '0;
      acc     <= '0;
    end else begin
      len     <= len_next;
      tpos    <= tpos_next;
      pidx    <= pidx_next;
      run     <= run_next;
      started <= started_next;
      prefix  <= prefix_next;
      prev    <= prev_next;
      acc     <= acc_next;
    end
  end

  fss_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (q_data)
  );

  assign m_tdata = q_data.score;
  assign m_tuser = q_data.matched;

endmodule
`default_nettype wire

### tb/fuzzy_subsequence_scorer_core_tb.sv
// self-checking testbench for the fuzzy subsequence scorer core, with a scoring model
module fuzzy_subsequence_scorer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fss_pkg::*;

  localparam int     TAIL_ITEMS = 150;
  localparam int     RANDOM_ITEMS = 650;
  localparam longint SCORE_CAP = 2147483647;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       last;
  } scan_item_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic [1:0]  s_tuser = OP_CLEAR;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  scan_item_t pending_items[$];
  result_t    expected_results[$];

  // scoring model state
  logic [7:0]  pat_mem [PAT_DEPTH];
  int unsigned pat_len = 0;
  int unsigned txt_pos = 0;
  int unsigned pat_idx = 0;
  int unsigned run_len = 0;
  bit          started = 1'b0;
  bit          prefix_eq = 1'b1;
  longint      acc = 0;

  int  items_accepted = 0;
  int  results_checked = 0;
  int  hits = 0;
  int  mismatches = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  logic calm = 1'b0;
  logic idle_phase = 1'b1;

  always #2 clk = ~clk;

  fuzzy_subsequence_scorer_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  function automatic logic [7:0] to_lower(logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    return c == "/" || c == "_" || c == "-" || c == ".";
  endfunction

  function automatic void reset_scan();
    txt_pos = 0;
    pat_idx = 0;
    run_len = 0;
    started = 1'b0;
    prefix_eq = 1'b1;
    acc = 0;
  endfunction

  // previous byte is only read when txt_pos > 0, so it lives in prev_ch
  logic [7:0] prev_ch = 8'd0;

  function automatic void scan_text_byte(logic [7:0] c);
    logic [7:0] fc;
    fc = to_lower(c);
    if (txt_pos < pat_len) begin
      if (fc != to_lower(pat_mem[txt_pos])) begin
        prefix_eq = 1'b0;
      end
    end
    if (pat_idx < pat_len) begin
      if (fc != to_lower(pat_mem[pat_idx])) begin
        run_len = 0;
        if (started) begin
          acc -= 1;
        end
      end else begin
        started = 1'b1;
        acc += PTS_MATCH;
        run_len++;
        if (run_len >= 2) begin
          acc += longint'(PTS_RUN) * run_len;
        end
        if (txt_pos == 0) begin
          acc += PTS_START;
        end else if (is_delim(prev_ch)) begin
          acc += PTS_SEP;
        end
        pat_idx++;
      end
    end
    prev_ch = c;
    txt_pos++;
  endfunction

  function automatic result_t close_candidate();
    result_t r;
    longint  s;
    r.score = '0;
    r.matched = 1'b0;
    if (pat_len == 0) begin
      r.score = SCORE_EMPTY;
      r.matched = 1'b1;
    end else if (pat_len > txt_pos) begin
      r.matched = 1'b0;
    end else if (prefix_eq) begin
      r.score = (txt_pos == pat_len) ? SCORE_EXACT : SCORE_PREFIX;
      r.matched = 1'b1;
    end else if (pat_idx >= pat_len) begin
      s = acc - longint'(txt_pos);
      if (s > SCORE_CAP) s = SCORE_CAP;
      if (s < -SCORE_CAP) s = -SCORE_CAP;
      r.score = s[31:0];
      r.matched = 1'b1;
    end
    reset_scan();
    prev_ch = 8'd0;
    return r;
  endfunction

  function automatic void apply_item(scan_item_t it);
    case (it.op)
      OP_CLEAR: begin
        pat_len = 0;
        reset_scan();
        prev_ch = 8'd0;
      end
      OP_APPEND: begin
        if (pat_len < PAT_DEPTH) begin
          pat_mem[pat_len] = it.ch;
          pat_len++;
        end
        reset_scan();
        prev_ch = 8'd0;
      end
      OP_TEXT: begin
        if (txt_pos < TEXT_LIMIT) begin
          scan_text_byte(it.ch);
        end
        if (it.last) begin
          expected_results.push_back(close_candidate());
        end
      end
      default: begin
        reset_scan();
        expected_results.push_back(close_candidate());
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // driver: one item in flight, predicted when the handshake completes
  always @(posedge clk) begin
    scan_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_item({s_tuser, s_tdata, s_tlast});
        items_accepted++;
      end
      calm <= pending_items.size() < TAIL_ITEMS;
      if ($urandom_range(0, 255) == 0) begin
        idle_phase <= !idle_phase;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (idle_phase && !calm && $urandom_range(0, 11) == 0) begin
          tx_gap = $urandom_range(0, 9);
          s_tvalid <= 1'b0;
        end else begin
          nxt = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.ch;
          s_tuser <= nxt.op;
          s_tlast <= nxt.last;
        end
      end
    end
  end

  // monitor: compare each result with the oldest expected score and matched flag
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: score %0d matched %0d",
                                    $signed(m_tdata), m_tuser));
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.score) begin
            report_mismatch($sformatf("result %0d score %0d, want %0d", results_checked,
                                      $signed(m_tdata), $signed(want.score)));
          end
          if (m_tuser !== want.matched) begin
            report_mismatch($sformatf("result %0d matched %0b, want %0b", results_checked,
                                      m_tuser, want.matched));
          end
          if (want.matched) hits++;
        end
        results_checked++;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else if (idle_phase && !calm && $urandom_range(0, 11) == 0) begin
        rx_gap = $urandom_range(0, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_item(logic [1:0] op, logic [7:0] ch, logic last);
    pending_items.push_back({op, ch, last});
  endtask

  function automatic byte_q_t to_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // fields that the block ignores are randomized: the clear byte and every last flag
  task automatic load_pattern(byte_q_t p);
    push_item(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    foreach (p[i]) push_item(OP_APPEND, p[i], 1'($urandom_range(0, 1)));
  endtask

  task automatic send_text(byte_q_t t, bit close);
    foreach (t[i]) push_item(OP_TEXT, t[i], close && i == t.size() - 1);
  endtask

  function automatic logic [7:0] noise_byte();
    string pool = "abcdeABCDE/_-.xyz";
    if ($urandom_range(0, 5) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1)) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  task automatic random_candidate(byte_q_t pat);
    byte_q_t t;
    int      n;
    case ($urandom_range(0, 9))
      0, 1: begin
        foreach (pat[i]) t.push_back(flip_case(pat[i]));
      end
      2: begin
        foreach (pat[i]) t.push_back(flip_case(pat[i]));
        n = $urandom_range(1, 4);
        repeat (n) t.push_back(noise_byte());
      end
      3, 4, 5, 6: begin
        foreach (pat[i]) begin
          n = $urandom_range(0, 3);
          repeat (n) t.push_back(noise_byte());
          t.push_back(flip_case(pat[i]));
        end
        n = $urandom_range(0, 3);
        repeat (n) t.push_back(noise_byte());
      end
      7: begin
        n = $urandom_range(1, 12);
        repeat (n) t.push_back(noise_byte());
      end
      8: begin
        // one byte short of the pattern
        for (int i = 0; i + 1 < pat.size(); i++) t.push_back(flip_case(pat[i]));
      end
      default: begin
        t.delete();
      end
    endcase
    if (t.size() == 0) begin
      push_item(OP_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      send_text(t, 1'b1);
    end
  endtask

  initial begin
    byte_q_t gen_pat;
    byte_q_t part;
    int      base;
    int      pick;
    int      n;

    // directed: empty pattern, exact, prefix, separators, runs, abandoned candidates
    push_item(OP_EMPTY, 8'hff, 1'b1);
    push_item(OP_TEXT, 8'h00, 1'b1);
    load_pattern(to_bytes("Ab"));
    send_text(to_bytes("aB"), 1'b1);
    send_text(to_bytes("ab_"), 1'b1);
    send_text(to_bytes("x_a-b"), 1'b1);
    send_text(to_bytes("a"), 1'b1);
    push_item(OP_TEXT, "q", 1'b0);
    push_item(OP_EMPTY, 8'hff, 1'b1);
    push_item(OP_TEXT, "a", 1'b0);
    push_item(OP_APPEND, "c", 1'b0);
    send_text(to_bytes("xabc"), 1'b1);

    // pattern overflow: appends past the depth are dropped
    gen_pat.delete();
    repeat (PAT_DEPTH + 6) gen_pat.push_back(noise_byte());
    load_pattern(gen_pat);
    gen_pat = gen_pat[0:PAT_DEPTH-1];
    repeat (2) random_candidate(gen_pat);

    // random: mostly well-formed candidates against short patterns, some noise
    gen_pat = to_bytes("ab");
    load_pattern(gen_pat);
    base = pending_items.size();
    while (pending_items.size() - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        gen_pat.delete();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 5);
        repeat (n) gen_pat.push_back(noise_byte());
        load_pattern(gen_pat);
      end else if (pick == 2) begin
        push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (pick == 3) begin
        // candidate cut short by a pattern reload
        part.delete();
        n = $urandom_range(1, 4);
        repeat (n) part.push_back(noise_byte());
        send_text(part, 1'b0);
        load_pattern(gen_pat);
      end else begin
        random_candidate(gen_pat);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d items in, %0d results checked, %0d of them matched", items_accepted,
             results_checked, hits);
    $display("ran pattern overflow, abandoned candidates and random candidates");
    if (mismatches == 0) begin
      $display("fuzzy_subsequence_scorer_core: match");
    end else begin
      $display("fuzzy_subsequence_scorer_core: mismatch");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d items pending, %0d results outstanding",
             pending_items.size(), expected_results.size());
    $display("fuzzy_subsequence_scorer_core: mismatch");
    $finish;
  end

endmodule

### sim.f
rtl/core/fss_pkg.sv
rtl/core/fss_ram.sv
rtl/core/fss_out_queue.sv
rtl/core/fuzzy_subsequence_scorer_core.sv
tb/fuzzy_subsequence_scorer_core_tb.sv
